// File: hw/rtl/acf_pkg.sv
package acf_pkg;

    typedef logic [7:0] byte_t;

    // Frame layout: '/', id tens, id ones, access, sign, five digits, newline
    localparam int FRAME_LEN       = 11;
    localparam int CELL_COUNT      = FRAME_LEN - 1;
    localparam int POS_ID_TENS     = 1;
    localparam int POS_ID_ONES     = 2;
    localparam int POS_ACCESS      = 3;
    localparam int POS_SIGN        = 4;
    localparam int POS_FIRST_DIGIT = 5;
    localparam int POS_LAST_DIGIT  = 9;
    localparam int POS_STOP        = FRAME_LEN - 1;
    localparam int NUM_DIGITS      = POS_LAST_DIGIT - POS_FIRST_DIGIT + 1;

    // Character codes
    localparam byte_t CH_START = 8'h2F;
    localparam byte_t CH_STOP  = 8'h0A;
    localparam byte_t CH_ZERO  = 8'h30;
    localparam byte_t CH_MINUS = 8'h2D;
    localparam byte_t CH_PLUS  = 8'h2B;

    // Input item kinds and result kinds
    localparam logic KIND_RX     = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;
    localparam logic OUT_CMD     = 1'b0;
    localparam logic OUT_TX      = 1'b1;

    // Decimal weights of the five value digits, most significant first
    localparam logic [13:0] DIGIT_WEIGHT [NUM_DIGITS] =
        '{14'd10000, 14'd1000, 14'd100, 14'd10, 14'd1};

    // Control from the top level to the answer sequencer
    typedef struct packed {
        logic start;
        logic advance;
    } acf_ans_ctl_t;

    // Status from the answer sequencer
    typedef struct packed {
        logic  busy;
        logic  last;
        byte_t tx_byte;
    } acf_ans_stat_t;

    // Decimal digit of v at weight w, given v < 10*w; w is a constant at each call
    function automatic logic [3:0] acf_digit(input logic [15:0] v, input logic [13:0] w);
        logic [3:0] d;
        d = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (20'(v) >= 20'(k) * 20'(w)) begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

endpackage

// File: hw/rtl/acf_cell.sv
module acf_cell (
    input  logic          aclk,
    input  logic          shift_en,
    input  acf_pkg::byte_t d_in,
    output acf_pkg::byte_t q
);
    import acf_pkg::*;

    byte_t data_reg;

    // One frame position; takes the byte at d_in on each captured word
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= d_in;
        end
    end

    assign q = data_reg;

endmodule

// File: hw/rtl/acf_answer.sv
module acf_answer (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  acf_pkg::acf_ans_ctl_t  ctl,
    input  logic [6:0]             start_id,
    input  logic signed [15:0]     start_value,
    output acf_pkg::acf_ans_stat_t stat
);
    import acf_pkg::*;

    logic        active_reg, active_next;
    logic [3:0]  idx_reg, idx_next;
    logic [6:0]  id_reg;
    logic        neg_reg;
    logic [15:0] rem_reg, rem_next;

    logic [3:0]  dig [NUM_DIGITS];
    logic [15:0] dig_sub [NUM_DIGITS];
    logic [2:0]  dsel;
    logic        in_digits;
    logic [3:0]  id_tens;
    logic [3:0]  id_ones;
    byte_t       tx_byte;

    // One decimal digit per value position, peeled off the remaining magnitude
    always_comb begin
        for (int j = 0; j < NUM_DIGITS; j++) begin
            dig[j]     = acf_digit(rem_reg, DIGIT_WEIGHT[j]);
            dig_sub[j] = 16'(20'(dig[j]) * 20'(DIGIT_WEIGHT[j]));
        end
    end

    assign in_digits = (idx_reg >= 4'(POS_FIRST_DIGIT)) && (idx_reg <= 4'(POS_LAST_DIGIT));
    assign dsel      = 3'(idx_reg - 4'(POS_FIRST_DIGIT));

    // Id digits (id already reduced below 100)
    assign id_tens = acf_digit(16'(id_reg), 14'd10);
    assign id_ones = 4'(id_reg - 7'(11'(id_tens) * 11'd10));

    // Byte for the current frame position
    always_comb begin
        case (idx_reg)
            4'(POS_ID_TENS): tx_byte = CH_ZERO + 8'(id_tens);
            4'(POS_ID_ONES): tx_byte = CH_ZERO + 8'(id_ones);
            4'(POS_ACCESS):  tx_byte = CH_ZERO;
            4'(POS_SIGN):    tx_byte = neg_reg ? CH_MINUS : CH_PLUS;
            4'(POS_STOP):    tx_byte = CH_STOP;
            default: begin
                if (in_digits) begin
                    tx_byte = CH_ZERO + 8'(dig[dsel]);
                end else begin
                    tx_byte = CH_START;
                end
            end
        endcase
    end

    // Sequencer: position counter and remaining magnitude
    always_comb begin
        active_next = active_reg;
        idx_next    = idx_reg;
        rem_next    = rem_reg;
        if (ctl.start) begin
            active_next = 1'b1;
            idx_next    = 4'(POS_ID_TENS);
            rem_next    = start_value[15] ? 16'(-start_value) : 16'(start_value);
        end else if (ctl.advance && active_reg) begin
            idx_next = idx_reg + 4'd1;
            if (idx_reg == 4'(POS_STOP)) begin
                active_next = 1'b0;
            end
            if (in_digits) begin
                rem_next = rem_reg - dig_sub[dsel];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end else begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        if (ctl.start) begin
            id_reg  <= (start_id >= 7'd100) ? 7'(start_id - 7'd100) : start_id;
            neg_reg <= start_value[15];
        end
    end

    assign stat.busy    = active_reg;
    assign stat.last    = (idx_reg == 4'(POS_STOP));
    assign stat.tx_byte = tx_byte;

endmodule

// File: hw/rtl/ascii_command_frame_codec.sv
// Channel  Dir  Handshake          Word
// s_       in   s_valid/s_ready    s_kind, s_rx_byte, s_answer_id, s_answer_value
// m_       out  m_valid/m_ready    m_out_kind, m_cmd_id, m_cmd_write, m_cmd_value,
//                                  m_tx_byte, m_last
//
// A received byte is taken on its handshake; the byte that ends a frame puts its
// command in the output register on the next cycle.
// An answer request puts out eleven words, one per cycle the sink takes a word;
// the single output register sets that pace and input waits meanwhile.
// aresetn (synchronous, active low) clears capture and answer control.
// Bytes that produce no word are taken even while the output register is full.
module ascii_command_frame_codec (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [7:0]         s_rx_byte,
    input  logic [6:0]         s_answer_id,
    input  logic signed [15:0] s_answer_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_out_kind,
    output logic [7:0]         m_cmd_id,
    output logic               m_cmd_write,
    output logic signed [15:0] m_cmd_value,
    output logic [7:0]         m_tx_byte,
    output logic               m_last
);
    import acf_pkg::*;

    // Capture control
    logic        capturing_reg, capturing_next;
    logic [3:0]  count_reg, count_next;
    logic [15:0] acc_reg, acc_next;

    // Output register
    logic               m_valid_reg, m_valid_next;
    logic               out_kind_reg, out_kind_next;
    byte_t              cmd_id_reg, cmd_id_next;
    logic               cmd_write_reg, cmd_write_next;
    logic signed [15:0] cmd_value_reg, cmd_value_next;
    byte_t              tx_byte_reg, tx_byte_next;
    logic               last_reg, last_next;
    logic               load_out;

    byte_t cell_in [CELL_COUNT];
    byte_t cell_q  [CELL_COUNT];

    logic          s_fire;
    logic          is_start;
    logic          cap_now;
    logic [3:0]    pos;
    logic          frame_end;
    logic          shift_en;
    logic          out_free;
    logic          in_digits;
    byte_t         b0, b1, b2, b3, b4;
    byte_t         access;
    byte_t         id_calc;
    logic          cmd_ok;
    logic [15:0]   digit16;
    logic [15:0]   acc_base;
    logic [15:0]   value_calc;

    acf_ans_ctl_t  ans_ctl;
    acf_ans_stat_t ans_stat;

    assign s_fire    = s_valid && s_ready;
    assign is_start  = (s_rx_byte == CH_START);
    assign cap_now   = capturing_reg || is_start;
    assign pos       = is_start ? 4'd0 : count_reg;
    assign frame_end = (s_kind == KIND_RX) && cap_now && (pos == 4'(POS_STOP));
    assign shift_en  = s_fire && (s_kind == KIND_RX) && cap_now;
    assign out_free  = !m_valid_reg || m_ready;

    // Hold input only during an answer or when a word is due and the output is full
    assign s_ready = !ans_stat.busy && (out_free || !((s_kind == KIND_ANSWER) || cmd_ok));

    // Frame store: chain of byte cells, newest byte at cell 0
    generate
        for (genvar i = 0; i < CELL_COUNT; i++) begin : g_chain
            if (i == 0) begin : g_head
                assign cell_in[i] = s_rx_byte;
            end else begin : g_link
                assign cell_in[i] = cell_q[i-1];
            end
            acf_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .d_in     (cell_in[i]),
                .q        (cell_q[i])
            );
        end
    endgenerate

    // With the stop byte arriving, frame byte k sits in cell POS_STOP-1-k
    assign b0 = cell_q[POS_STOP - 1];
    assign b1 = cell_q[POS_STOP - 1 - POS_ID_TENS];
    assign b2 = cell_q[POS_STOP - 1 - POS_ID_ONES];
    assign b3 = cell_q[POS_STOP - 1 - POS_ACCESS];
    assign b4 = cell_q[POS_STOP - 1 - POS_SIGN];

    // Value digits accumulate as they arrive (wrapping 16-bit Horner form)
    assign in_digits = (pos >= 4'(POS_FIRST_DIGIT)) && (pos <= 4'(POS_LAST_DIGIT));
    assign digit16   = {8'd0, s_rx_byte} - {8'd0, CH_ZERO};
    assign acc_base  = (pos == 4'(POS_FIRST_DIGIT)) ? 16'd0 : acc_reg;

    // Frame check and command decode on the stop byte
    assign access     = b3 - CH_ZERO;
    assign id_calc    = 8'(16'(b1 - CH_ZERO) * 16'd10) + (b2 - CH_ZERO);
    assign cmd_ok     = frame_end && (b0 == CH_START) && (s_rx_byte == CH_STOP)
                        && (access[7:1] == 7'd0);
    assign value_calc = !access[0] ? 16'd0 : ((b4 == CH_MINUS) ? 16'(-acc_reg) : acc_reg);

    // Capture state
    always_comb begin
        capturing_next = capturing_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        if (shift_en) begin
            if (pos == 4'(POS_STOP)) begin
                capturing_next = 1'b0;
                count_next     = 4'd0;
            end else begin
                capturing_next = 1'b1;
                count_next     = pos + 4'd1;
            end
            if (in_digits) begin
                acc_next = acc_base * 16'd10 + digit16;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capturing_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            capturing_reg <= capturing_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // Answer sequencer
    assign ans_ctl.start   = s_fire && (s_kind == KIND_ANSWER);
    assign ans_ctl.advance = ans_stat.busy && out_free;

    acf_answer u_answer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ans_ctl),
        .start_id    (s_answer_id),
        .start_value (s_answer_value),
        .stat        (ans_stat)
    );

    // Output register load
    always_comb begin
        m_valid_next   = m_valid_reg;
        load_out       = 1'b0;
        out_kind_next  = OUT_TX;
        cmd_id_next    = '0;
        cmd_write_next = 1'b0;
        cmd_value_next = '0;
        tx_byte_next   = '0;
        last_next      = 1'b0;
        if (ans_ctl.advance) begin
            load_out     = 1'b1;
            tx_byte_next = ans_stat.tx_byte;
            last_next    = ans_stat.last;
        end else if (ans_ctl.start) begin
            load_out     = 1'b1;
            tx_byte_next = CH_START;
        end else if (s_fire && cmd_ok) begin
            load_out       = 1'b1;
            out_kind_next  = OUT_CMD;
            cmd_id_next    = id_calc;
            cmd_write_next = access[0];
            cmd_value_next = signed'(value_calc);
        end
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_kind_reg  <= out_kind_next;
            cmd_id_reg    <= cmd_id_next;
            cmd_write_reg <= cmd_write_next;
            cmd_value_reg <= cmd_value_next;
            tx_byte_reg   <= tx_byte_next;
            last_reg      <= last_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_kind  = out_kind_reg;
    assign m_cmd_id    = cmd_id_reg;
    assign m_cmd_write = cmd_write_reg;
    assign m_cmd_value = cmd_value_reg;
    assign m_tx_byte   = tx_byte_reg;
    assign m_last      = last_reg;

`ifndef NO_ASSERTIONS
    // Position counter never reaches the frame length
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg < 4'(FRAME_LEN))
        else $error("capture count out of range");

    // Idle capture always restarts at the first position
    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !capturing_reg |-> count_reg == 4'd0)
        else $error("count nonzero while not capturing");

    // An answer opens with its start byte in the output register
    a_answer_open: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ans_stat.busy) |-> m_valid_reg && tx_byte_reg == CH_START && !last_reg)
        else $error("answer did not open with start byte");

    // The closing newline leaves the sequencer idle
    a_answer_close: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && last_reg |-> !ans_stat.busy && tx_byte_reg == CH_STOP)
        else $error("last word without sequencer finishing");

    // No input word is taken during an answer
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ans_stat.busy |=> !$past(s_fire))
        else $error("input taken during answer");
`endif

endmodule
